@@ design/iptm_pkg.sv @@
// shared types, codes and constants for the idle power tier manager
`timescale 1ns / 1ps

package iptm_pkg;

   localparam int TIME_WIDTH_DEF = 48;

   // timeout in microseconds: 16-bit seconds times one million
   localparam int SEC_WIDTH = 16;
   localparam int US_PER_S_WIDTH = 20;
   localparam int DUR_WIDTH = SEC_WIDTH + US_PER_S_WIDTH;
   localparam logic [US_PER_S_WIDTH-1:0] US_PER_S = US_PER_S_WIDTH'(1000000);
   localparam logic [DUR_WIDTH-1:0] DOZE_RESET_US = DUR_WIDTH'(60 * 1000 * 1000);
   localparam logic [DUR_WIDTH-1:0] DEEP_RESET_US = '0;

   localparam int COUNT_WIDTH = 32;
   localparam int REFRESH_WIDTH = 9;
   localparam logic [REFRESH_WIDTH-1:0] LIVE_REFRESH_S = REFRESH_WIDTH'(60);
   localparam logic [REFRESH_WIDTH-1:0] DOZE_REFRESH_S = REFRESH_WIDTH'(300);

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DOZE_TIMEOUT = 2'd0,
      REG_DEEP_TIMEOUT = 2'd1,
      REG_WIFI_POLICY  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      POLICY_NONE      = 2'd0,
      POLICY_POWERSAVE = 2'd1,
      POLICY_DROP      = 2'd2
   } wifi_policy_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_RADIO_OFF  = 3'd1,
      CMD_RADIO_ON   = 3'd2,
      CMD_MODEM_DEEP = 3'd3,
      CMD_MODEM_MIN  = 3'd4
   } wifi_cmd_type;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_ACTIVITY = 1'b1;

   typedef struct packed {
      logic [DUR_WIDTH-1:0] doze_us;
      logic [DUR_WIDTH-1:0] deep_us;
      logic [1:0]           policy;
   } cfg_type;

endpackage

@@ design/iptm_csr.sv @@
// configuration registers, timeouts held pre-scaled to microseconds
`timescale 1ns / 1ps

module iptm_csr
   import iptm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   logic [DUR_WIDTH-1:0] doze_us_ff, doze_us_in;
   logic [DUR_WIDTH-1:0] deep_us_ff, deep_us_in;
   logic [1:0]           policy_ff, policy_in;
   logic [DUR_WIDTH-1:0] scaled_us;

   assign scaled_us = DUR_WIDTH'(csr_wdata) * DUR_WIDTH'(US_PER_S);

   always_comb begin
      doze_us_in = doze_us_ff;
      deep_us_in = deep_us_ff;
      policy_in  = policy_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DOZE_TIMEOUT: doze_us_in = scaled_us;
            REG_DEEP_TIMEOUT: deep_us_in = scaled_us;
            REG_WIFI_POLICY:  policy_in  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         doze_us_ff <= DOZE_RESET_US;
         deep_us_ff <= DEEP_RESET_US;
         policy_ff  <= POLICY_NONE;
      end else begin
         doze_us_ff <= doze_us_in;
         deep_us_ff <= deep_us_in;
         policy_ff  <= policy_in;
      end
   end

   assign cfg.doze_us = doze_us_ff;
   assign cfg.deep_us = deep_us_ff;
   assign cfg.policy  = policy_ff;

endmodule

@@ design/iptm_core.sv @@
// tier state, accumulators and single-pass transition logic
`timescale 1ns / 1ps

module iptm_core
   import iptm_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int RSP_DATA_W = 192
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  step,
   input  logic                  mode,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic                  inhibited,
   input  logic                  net_up,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int CMP_W = (TIME_WIDTH > DUR_WIDTH) ? TIME_WIDTH : DUR_WIDTH;

   logic                   tier_ff, tier_in;
   logic                   started_ff, started_in;
   logic [TIME_WIDTH-1:0]  last_act_ff, last_act_in;
   logic [TIME_WIDTH-1:0]  last_upd_ff, last_upd_in;
   logic [TIME_WIDTH-1:0]  entry_ff, entry_in;
   logic [TIME_WIDTH-1:0]  live_acc_ff, live_acc_in;
   logic [TIME_WIDTH-1:0]  doze_acc_ff, doze_acc_in;
   logic [COUNT_WIDTH-1:0] doze_cnt_ff, doze_cnt_in;
   logic                   link_ff, link_in;
   logic                   deep_ff, deep_in;
   logic                   dropped_ff, dropped_in;

   logic                   is_update, first_update;
   logic                   tier_base;
   logic [TIME_WIDTH-1:0]  last_upd_eff, last_act_eff, entry_eff;
   logic [TIME_WIDTH-1:0]  dt, idle, tier_age, deep_age;
   logic [TIME_WIDTH:0]    acc_sum;
   logic                   add_ok, want, change, link_cur, set_deep;
   logic [TIME_WIDTH-1:0]  prev;
   logic [2:0]             cmd;

   assign is_update    = (mode == MODE_UPDATE);
   assign first_update = is_update && !started_ff;
   assign tier_base    = first_update ? 1'b0 : tier_ff;
   assign last_upd_eff = first_update ? now : last_upd_ff;
   assign last_act_eff = (is_update && (!started_ff || inhibited)) ? now : last_act_ff;
   assign entry_eff    = first_update ? now : entry_ff;

   // elapsed time since previous update, added to the tier held before this update
   assign dt      = now - last_upd_eff;
   assign add_ok  = is_update && (now > last_upd_eff);
   assign acc_sum = {1'b0, (tier_base ? doze_acc_ff : live_acc_ff)} + {1'b0, dt};

   assign idle = now - last_act_eff;
   assign want = is_update && (cfg.doze_us != '0) && !inhibited && (now >= last_act_eff)
                 && (CMP_W'(idle) >= CMP_W'(cfg.doze_us));
   assign change   = (want != tier_base);
   assign link_cur = is_update ? net_up : link_ff;
   assign tier_age = now - entry_eff;
   assign prev     = (change && (now >= entry_eff)) ? tier_age : '0;

   always_comb begin
      cmd        = CMD_NONE;
      dropped_in = dropped_ff;
      if (change) begin
         case (cfg.policy)
            POLICY_DROP: begin
               if (want && link_cur) begin
                  cmd        = CMD_RADIO_OFF;
                  dropped_in = 1'b1;
               end else if (!want && dropped_ff) begin
                  cmd        = CMD_RADIO_ON;
                  dropped_in = 1'b0;
               end
            end
            POLICY_POWERSAVE: begin
               if (link_cur) begin
                  cmd = want ? CMD_MODEM_DEEP : CMD_MODEM_MIN;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      tier_in     = change ? want : tier_base;
      entry_in    = change ? now : entry_eff;
      started_in  = started_ff | is_update;
      link_in     = link_cur;
      last_act_in = is_update ? last_act_eff : now;
      last_upd_in = is_update ? now : last_upd_ff;
      live_acc_in = live_acc_ff;
      doze_acc_in = doze_acc_ff;
      if (add_ok) begin
         if (tier_base) begin
            doze_acc_in = acc_sum[TIME_WIDTH] ? '1 : acc_sum[TIME_WIDTH-1:0];
         end else begin
            live_acc_in = acc_sum[TIME_WIDTH] ? '1 : acc_sum[TIME_WIDTH-1:0];
         end
      end
      doze_cnt_in = doze_cnt_ff;
      if (change && want && (doze_cnt_ff != '1)) begin
         doze_cnt_in = doze_cnt_ff + COUNT_WIDTH'(1);
      end
   end

   assign deep_age = now - entry_in;
   assign set_deep = is_update && tier_in && (cfg.deep_us != '0) && (now >= entry_in)
                     && (CMP_W'(deep_age) >= CMP_W'(cfg.deep_us));
   assign deep_in  = set_deep | (deep_ff & !(change & !want));

   assign rsp_data = RSP_DATA_W'({(tier_in ? DOZE_REFRESH_S : LIVE_REFRESH_S), doze_cnt_in,
                                  doze_acc_in, live_acc_in, deep_in, tier_in, cmd, prev,
                                  change, tier_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         tier_ff     <= 1'b0;
         started_ff  <= 1'b0;
         last_act_ff <= '0;
         last_upd_ff <= '0;
         entry_ff    <= '0;
         live_acc_ff <= '0;
         doze_acc_ff <= '0;
         doze_cnt_ff <= '0;
         link_ff     <= 1'b0;
         deep_ff     <= 1'b0;
         dropped_ff  <= 1'b0;
      end else if (step) begin
         tier_ff     <= tier_in;
         started_ff  <= started_in;
         last_act_ff <= last_act_in;
         last_upd_ff <= last_upd_in;
         entry_ff    <= entry_in;
         live_acc_ff <= live_acc_in;
         doze_acc_ff <= doze_acc_in;
         doze_cnt_ff <= doze_cnt_in;
         link_ff     <= link_in;
         deep_ff     <= deep_in;
         dropped_ff  <= dropped_in;
      end
   end

   a_deep_only_in_doze: assert property (@(posedge clock) disable iff (reset)
      deep_ff |-> tier_ff)
      else $error("deep sleep request held while live");

   a_live_until_started: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> !tier_ff)
      else $error("doze before first update");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(tier_ff) && $stable(doze_cnt_ff) && $stable(live_acc_ff))
      else $error("state moved without a request");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      step |=> doze_cnt_ff >= $past(doze_cnt_ff))
      else $error("doze entry count went down");

endmodule

@@ design/idle_power_tier_manager_unit.sv @@
// Two-tier idle power manager: one request in, one result out.
// A request is held in the input register, then its result in the result register
// after the tier logic. Throughput: one request per cycle while rsp_tready is high;
// the input register refills while a result waits.
// Reset: synchronous, active high; clears tier state, counters and config to defaults.
`timescale 1ns / 1ps

module idle_power_tier_manager_unit
   import iptm_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   localparam int REQ_DATA_W = ((TIME_WIDTH + 2 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((3 * TIME_WIDTH + 48 + 7) / 8) * 8
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // now_us, inhibited, net_up
   input  logic [REQ_DATA_W-1:0]      req_tdata,
   // mode
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tier, tier_changed, prev_tier_us, wifi_command, touch_low_power,
   // deep_sleep_request, live_time_us, doze_time_us, doze_entries, refresh_period_s
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type               cfg;
   logic                  in_valid_ff, in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  in_mode_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] core_data;
   logic                  advance, take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take | (in_valid_ff & !advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & !rsp_tready);

   iptm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   iptm_core #(
      .TIME_WIDTH (TIME_WIDTH),
      .RSP_DATA_W (RSP_DATA_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (advance),
      .mode       (in_mode_ff),
      .now        (in_data_ff[TIME_WIDTH-1:0]),
      .inhibited  (in_data_ff[TIME_WIDTH]),
      .net_up     (in_data_ff[TIME_WIDTH+1]),
      .rsp_data   (core_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_tdata;
         in_mode_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= core_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
